// ===== rtl/plen_pkg.sv =====
`default_nettype none
package plen_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;

    // fixed field widths
    localparam int FUNC_W  = 3;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // derived storage widths
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    // request codes
    localparam logic [FUNC_W-1:0] FN_INSERT_AT    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_APPEND       = 3'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE_AT    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_REMOVE_FIRST = 3'd3;
    localparam logic [FUNC_W-1:0] FN_REMOVE_LAST  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_FIND         = 3'd5;
    localparam logic [FUNC_W-1:0] FN_COUNT        = 3'd6;
    localparam logic [FUNC_W-1:0] FN_READ_AT      = 3'd7;

    typedef struct packed {
        logic clr;
        logic en;
    } match_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/positional_list_engine.sv =====
`default_nettype none
// positional list engine: ordered list of up to CAPACITY values, 1-based positions
//
// request channel: in_valid / in_stall carry func, position and value; a transfer
// happens at a clock edge with in_valid high and in_stall low
// result channel: out_valid / out_stall carry ok, found, match_count, read_value
// and items; exactly one result per request, in request order
//
// one request is worked at a time by a small sequencer around an entry memory
// with one write port and a registered read port; the read/write pipeline
// moves one entry per cycle. a request walks the shifted entries for
// insert/remove, the whole list for find/count, one entry for read; some walk
// nothing (append, remove_last, rejected requests, find/count on an empty
// list). the longest request is find/count on a full list; the next request
// can transfer at the first edge after the result appears
//
// reset clears the entry count and the sequencer; entry contents are not
// cleared. a stalled result is held in the output register and the next
// request is held off until that result transfers
module positional_list_engine (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [plen_pkg::FUNC_W-1:0]  func,
    input  wire logic [plen_pkg::POS_W-1:0]   position,
    input  wire logic [plen_pkg::VALUE_W-1:0] value,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              ok,
    output logic                              found,
    output logic      [plen_pkg::COUNT_W-1:0] match_count,
    output logic      [plen_pkg::VALUE_W-1:0] read_value,
    output logic      [plen_pkg::COUNT_W-1:0] items
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    localparam int IW = plen_pkg::IDX_W;
    localparam int CW = plen_pkg::CNT_W;
    localparam int MW = plen_pkg::CMP_W;
    localparam int DW = plen_pkg::DATA_W;

    // sequencer state
    logic                             state_reg, state_next;
    logic [plen_pkg::FUNC_W-1:0]      op_reg, op_next;
    logic                             ok_reg, ok_next;
    logic [CW-1:0]                    rem_reg, rem_next;     // reads left to issue
    logic [IW-1:0]                    cur_reg, cur_next;     // next read address
    logic [IW-1:0]                    tgt_reg, tgt_next;     // insert slot
    logic                             pend_reg, pend_next;   // read data arriving
    logic [IW-1:0]                    paddr_reg, paddr_next;
    logic [DW-1:0]                    val_reg, val_next;
    logic [DW-1:0]                    rdv_reg, rdv_next;
    logic [CW-1:0]                    cnt_reg, cnt_next;

    // output register
    logic                             ovalid_reg, ovalid_next;
    logic                             ook_reg, ook_next;
    logic                             ofound_reg, ofound_next;
    logic [plen_pkg::COUNT_W-1:0]     omc_reg, omc_next;
    logic [plen_pkg::VALUE_W-1:0]     ord_reg, ord_next;
    logic [plen_pkg::COUNT_W-1:0]     oitems_reg, oitems_next;

    // memory and compare unit hookup
    logic                             mem_we;
    logic [IW-1:0]                    mem_waddr;
    logic [DW-1:0]                    mem_wdata;
    logic [DW-1:0]                    mem_rdata;
    plen_pkg::match_ctl_t             mctl;
    logic [CW-1:0]                    mcount;

    logic                             accept;
    logic                             finish;
    logic                             is_ins, is_rem, is_scan;
    logic [MW-1:0]                    n_ext, ep, cap_ext;
    logic                             full, in_rng, ins_rng;

    plen_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (cur_reg),
        .rdata (mem_rdata)
    );

    plen_match u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mctl),
        .a     (mem_rdata),
        .b     (val_reg),
        .count (mcount)
    );

    assign in_stall = (state_reg != S_IDLE) || (ovalid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    // request decode: effective 1-based position and range checks
    assign n_ext   = MW'(cnt_reg);
    assign cap_ext = MW'(plen_pkg::CAPACITY);
    assign full    = (n_ext >= cap_ext);

    always_comb
    begin
        unique case (func)
            plen_pkg::FN_APPEND:       ep = n_ext + MW'(1);
            plen_pkg::FN_REMOVE_FIRST: ep = MW'(1);
            plen_pkg::FN_REMOVE_LAST:  ep = n_ext;
            default:                   ep = MW'(position);
        endcase
    end

    assign in_rng  = (ep != '0) && (ep <= n_ext);
    assign ins_rng = (ep != '0) && (ep <= n_ext + MW'(1));

    // op class of the request in flight
    assign is_ins  = (op_reg == plen_pkg::FN_INSERT_AT) || (op_reg == plen_pkg::FN_APPEND);
    assign is_rem  = (op_reg == plen_pkg::FN_REMOVE_AT) || (op_reg == plen_pkg::FN_REMOVE_FIRST)
                  || (op_reg == plen_pkg::FN_REMOVE_LAST);
    assign is_scan = (op_reg == plen_pkg::FN_FIND) || (op_reg == plen_pkg::FN_COUNT);

    assign finish = (state_reg == S_RUN) && (rem_reg == '0) && !pend_reg;

    assign mctl.clr = accept;
    assign mctl.en  = (state_reg == S_RUN) && pend_reg && is_scan;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        ok_next     = ok_reg;
        rem_next    = rem_reg;
        cur_next    = cur_reg;
        tgt_next    = tgt_reg;
        pend_next   = 1'b0;
        paddr_next  = paddr_reg;
        val_next    = val_reg;
        rdv_next    = rdv_reg;
        cnt_next    = cnt_reg;
        mem_we      = 1'b0;
        mem_waddr   = tgt_reg;
        mem_wdata   = val_reg;

        ovalid_next = ovalid_reg && out_stall;
        ook_next    = ook_reg;
        ofound_next = ofound_reg;
        omc_next    = omc_reg;
        ord_next    = ord_reg;
        oitems_next = oitems_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                    op_next    = func;
                    val_next   = DW'(value);
                    tgt_next   = IW'(ep - MW'(1));
                    rem_next   = '0;
                    cur_next   = '0;
                    ok_next    = 1'b0;
                    unique case (func) inside
                        plen_pkg::FN_INSERT_AT, plen_pkg::FN_APPEND:
                        begin
                            ok_next = !full && ins_rng;
                            if (!full && ins_rng)
                            begin
                                // shift entries ep-1 .. n-1 up by one, top first
                                rem_next = CW'(n_ext + MW'(1) - ep);
                                cur_next = IW'(n_ext - MW'(1));
                            end
                        end
                        plen_pkg::FN_REMOVE_AT, plen_pkg::FN_REMOVE_FIRST,
                        plen_pkg::FN_REMOVE_LAST:
                        begin
                            ok_next = in_rng;
                            if (in_rng)
                            begin
                                // shift entries ep .. n-1 down by one
                                rem_next = CW'(n_ext - ep);
                                cur_next = IW'(ep);
                            end
                        end
                        plen_pkg::FN_FIND, plen_pkg::FN_COUNT:
                        begin
                            ok_next  = 1'b1;
                            rem_next = cnt_reg;
                        end
                        default:
                        begin
                            ok_next = in_rng;
                            if (in_rng)
                            begin
                                rem_next = CW'(1);
                                cur_next = IW'(ep - MW'(1));
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                // issue one read per cycle
                if (rem_reg != '0)
                begin
                    rem_next   = rem_reg - CW'(1);
                    pend_next  = 1'b1;
                    paddr_next = cur_reg;
                    cur_next   = is_ins ? cur_reg - IW'(1) : cur_reg + IW'(1);
                end

                // retire the read issued last cycle
                if (pend_reg)
                begin
                    if (is_ins)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = paddr_reg + IW'(1);
                        mem_wdata = mem_rdata;
                    end
                    else if (is_rem)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = paddr_reg - IW'(1);
                        mem_wdata = mem_rdata;
                    end
                    else if (op_reg == plen_pkg::FN_READ_AT)
                    begin
                        rdv_next = mem_rdata;
                    end
                end

                if (finish)
                begin
                    state_next = S_IDLE;
                    if (ok_reg && is_ins)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = tgt_reg;
                        mem_wdata = val_reg;
                        cnt_next  = cnt_reg + CW'(1);
                    end
                    else if (ok_reg && is_rem)
                    begin
                        cnt_next = cnt_reg - CW'(1);
                    end
                    ovalid_next = 1'b1;
                    ook_next    = ok_reg;
                    ofound_next = (op_reg == plen_pkg::FN_FIND) && (mcount != '0);
                    omc_next    = (op_reg == plen_pkg::FN_COUNT)
                                  ? plen_pkg::COUNT_W'(mcount) : '0;
                    ord_next    = ((op_reg == plen_pkg::FN_READ_AT) && ok_reg)
                                  ? plen_pkg::VALUE_W'(rdv_reg) : '0;
                    oitems_next = plen_pkg::COUNT_W'(cnt_next);
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rem_reg    <= '0;
            pend_reg   <= 1'b0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rem_reg    <= rem_next;
            pend_reg   <= pend_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload and work registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        ok_reg     <= ok_next;
        cur_reg    <= cur_next;
        tgt_reg    <= tgt_next;
        paddr_reg  <= paddr_next;
        val_reg    <= val_next;
        rdv_reg    <= rdv_next;
        ook_reg    <= ook_next;
        ofound_reg <= ofound_next;
        omc_reg    <= omc_next;
        ord_reg    <= ord_next;
        oitems_reg <= oitems_next;
    end

    assign out_valid   = ovalid_reg;
    assign ok          = ook_reg;
    assign found       = ofound_reg;
    assign match_count = omc_reg;
    assign read_value  = ord_reg;
    assign items       = oitems_reg;

endmodule
`default_nettype wire

// ===== rtl/plen_mem.sv =====
`default_nettype none
module plen_mem (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [plen_pkg::IDX_W-1:0]  waddr,
    input  wire logic [plen_pkg::DATA_W-1:0] wdata,
    input  wire logic [plen_pkg::IDX_W-1:0]  raddr,
    output logic      [plen_pkg::DATA_W-1:0] rdata
);

    logic [plen_pkg::DATA_W-1:0] mem [plen_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/plen_match.sv =====
`default_nettype none
module plen_match (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire plen_pkg::match_ctl_t        ctl,
    input  wire logic [plen_pkg::DATA_W-1:0] a,
    input  wire logic [plen_pkg::DATA_W-1:0] b,
    output logic      [plen_pkg::CNT_W-1:0]  count
);

    logic [plen_pkg::CNT_W-1:0] count_reg;
    logic [plen_pkg::CNT_W-1:0] count_next;

    // shared equality compare, one entry per cycle
    always_comb
    begin
        count_next = count_reg;
        if (ctl.clr)
        begin
            count_next = '0;
        end
        else if (ctl.en && (a == b))
        begin
            count_next = count_reg + plen_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule
`default_nettype wire
